/* rtl/rcp_pkg.sv */
// ----------------------------------------------------------------------------
// rcp_pkg: shared constants of the rectangle canvas painter
// Command, status and register codes, mode characters, default sizes.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 8;
  localparam int DEF_COORD_BITS = 20;

  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Commands
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] RST_CANVAS_HEIGHT = 9'd256;
  localparam logic [CHAR_W-1:0]     RST_BACKGROUND    = 8'd32;

  // Mode characters
  localparam logic [CHAR_W-1:0] MODE_OUTLINE = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] MODE_FILLED  = 8'h52;  // 'R'

endpackage

/* rtl/rcp_if.sv */
// ----------------------------------------------------------------------------
// rcp_if: channel interfaces of the rectangle canvas painter
// Command, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rcp_in_if #(
  parameter int COORD_BITS = rcp_pkg::DEF_COORD_BITS
);
  import rcp_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [CHAR_W-1:0]            mode_char;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic signed [COORD_BITS-1:0] rect_width;
  logic signed [COORD_BITS-1:0] rect_height;
  logic [CHAR_W-1:0]            paint_char;
  logic [7:0]                   read_row;
  logic [7:0]                   read_col;

  modport source (
    output valid, command, mode_char, rect_x, rect_y, rect_width, rect_height,
           paint_char, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, command, mode_char, rect_x, rect_y, rect_width, rect_height,
           paint_char, read_row, read_col,
    output ready
  );
endinterface

interface rcp_out_if;
  import rcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [1:0]        status;

  modport source (output valid, cell_char, status, input ready);
  modport sink   (input valid, cell_char, status, output ready);
endinterface

interface rcp_cfg_if;
  import rcp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rectangle_canvas_painter.sv */
// ----------------------------------------------------------------------------
// rectangle_canvas_painter: character canvas with rectangle rasterizer
// Clears, paints rectangles onto and reads back a character canvas.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : command transfers (draw, read, clear). Ready is high only while
//           the sequencer is idle; one command is worked on at a time.
//   out_o : one result transfer per command (cell_char, status).
//   cfg_i : register writes (width, height, background); always ready.
//           Write only while no command is in flight.
// Sequence, from the input transfer to the result being valid:
//   draw or clear: a scan that visits one canvas cell per cycle through the
//                  single memory write port, over every row and column in use.
//   read: one registered memory read (S_READ), then S_DONE.
//   draw with an error, read outside the canvas, unused command: straight to S_DONE.
// Ready returns in the same cycle as the result becomes valid in the output
// register, so a new command can start while that result waits. If the
// receiver still holds off a result when the next one is done, the sequencer
// waits with that result and takes no command.
// Reset clears the control state and loads the register defaults; the
// canvas memory is not cleared and holds garbage until a clear command.
// ----------------------------------------------------------------------------
module rectangle_canvas_painter #(
  parameter int MAX_WIDTH  = rcp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rcp_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = rcp_pkg::DEF_FRAC_BITS,
  parameter int COORD_BITS = rcp_pkg::DEF_COORD_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rcp_in_if.sink    in_i,
  rcp_out_if.source out_o,
  rcp_cfg_if.sink   cfg_i
);
  import rcp_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W = CW + RW;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int SPAN   = (COORD_BITS > 11 + FRAC_BITS) ? COORD_BITS : 11 + FRAC_BITS;
  localparam int SW     = SPAN + 2;
  localparam logic [SW-1:0] FRAC_MASK = SW'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [CHAR_W-1:0]     bg_q;
  logic                  out_valid_q;
  logic [CHAR_W-1:0]     out_cell_q;
  logic [1:0]            out_status_q;

  logic [RW-1:0]         row_q, row_d;
  logic [CW-1:0]         col_q, col_d;
  logic signed [SW-1:0]  xs0_q, ys0_q, xb_q, yb_q;
  logic                  outline_q, clear_q, cell_sel_q;
  logic [CHAR_W-1:0]     paint_q;
  logic [1:0]            status_q, status_d;
  logic [CHAR_W-1:0]     rd_q;
  logic [CHAR_W-1:0]     mem_q [DEPTH];

  logic [CW:0]           cols;
  logic [RW:0]           rows;
  logic [CW:0]           cols_m1;
  logic [RW:0]           rows_m1;
  logic                  last_col, last_row;
  logic                  accept, cfg_accept, load_out, hit, we;
  logic [CW:0]           col_inc;
  logic [RW:0]           row_inc;
  logic signed [SW-1:0]  js, jsn, is_s, isn_s;
  logic signed [SW-1:0]  rx, ry, rw, rh;
  logic                  mode_ok, size_ok, read_in;

  // Canvas size in use, with zero acting as one and saturation at the maximum
  always_comb begin
    if (width_q == '0) begin
      cols = (CW+1)'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      cols = (CW+1)'(MAX_WIDTH);
    end else begin
      cols = (CW+1)'(width_q);
    end
    if (height_q == '0) begin
      rows = (RW+1)'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      rows = (RW+1)'(MAX_HEIGHT);
    end else begin
      rows = (RW+1)'(height_q);
    end
  end

  assign cols_m1  = cols - (CW+1)'(1);
  assign rows_m1  = rows - (RW+1)'(1);
  assign last_col = (col_q == cols_m1[CW-1:0]);
  assign last_row = (row_q == rows_m1[RW-1:0]);

  assign accept     = in_i.valid && in_i.ready;
  assign cfg_accept = cfg_i.valid && cfg_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Command decode
  assign rx      = SW'(in_i.rect_x);
  assign ry      = SW'(in_i.rect_y);
  assign rw      = SW'(in_i.rect_width);
  assign rh      = SW'(in_i.rect_height);
  assign mode_ok = (in_i.mode_char == MODE_OUTLINE) || (in_i.mode_char == MODE_FILLED);
  assign size_ok = (in_i.rect_width > 0) && (in_i.rect_height > 0);
  assign read_in = (32'(in_i.read_row) < 32'(rows)) && (32'(in_i.read_col) < 32'(cols));

  // Scaled cell coordinates
  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);
  assign js      = $signed(SW'(col_q) << FRAC_BITS);
  assign jsn     = $signed(SW'(col_inc) << FRAC_BITS);
  assign is_s    = $signed(SW'(row_q) << FRAC_BITS);
  assign isn_s   = $signed(SW'(row_inc) << FRAC_BITS);

  rcp_hit #(.SW(SW)) u_hit (
    .outline_i (outline_q),
    .js_i      (js),
    .jsn_i     (jsn),
    .is_i      (is_s),
    .isn_i     (isn_s),
    .xs0_i     (xs0_q),
    .ys0_i     (ys0_q),
    .xb_i      (xb_q),
    .yb_i      (yb_q),
    .hit_o     (hit)
  );

  assign we       = (state_q == S_SCAN) && (clear_q || hit);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          row_d    = '0;
          col_d    = '0;
          unique case (in_i.command)
            CMD_DRAW: begin
              if (!mode_ok) begin
                status_d = ST_BAD_MODE;
                state_d  = S_DONE;
              end else if (!size_ok) begin
                status_d = ST_BAD_SIZE;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_READ: begin
              if (read_in) begin
                row_d   = RW'(in_i.read_row);
                col_d   = CW'(in_i.read_col);
                state_d = S_READ;
              end else begin
                status_d = ST_OUTSIDE;
                state_d  = S_DONE;
              end
            end
            CMD_CLEAR: state_d = S_SCAN;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (last_col) begin
          col_d = '0;
          row_d = row_inc[RW-1:0];
          if (last_row) begin
            state_d = S_DONE;
          end
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end
      S_READ: state_d = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      width_q     <= RST_CANVAS_WIDTH;
      height_q    <= RST_CANVAS_HEIGHT;
      bg_q        <= RST_BACKGROUND;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_accept) begin
        unique case (cfg_i.index)
          CFG_CANVAS_WIDTH:  width_q  <= cfg_i.data;
          CFG_CANVAS_HEIGHT: height_q <= cfg_i.data;
          CFG_BACKGROUND:    bg_q     <= cfg_i.data[CHAR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    status_q <= status_d;
    if (accept) begin
      xs0_q      <= $signed(rx & ~FRAC_MASK);
      ys0_q      <= $signed(ry & ~FRAC_MASK);
      xb_q       <= rx + rw;
      yb_q       <= ry + rh;
      outline_q  <= (in_i.mode_char == MODE_OUTLINE);
      clear_q    <= (in_i.command == CMD_CLEAR);
      paint_q    <= in_i.paint_char;
      cell_sel_q <= (in_i.command == CMD_READ) && read_in;
    end
    if (load_out) begin
      out_cell_q   <= cell_sel_q ? rd_q : '0;
      out_status_q <= status_q;
    end
  end

  // Canvas memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[{row_q, col_q}] <= clear_q ? bg_q : paint_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_q <= mem_q[{row_q, col_q}];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cell_char = out_cell_q;
  assign out_o.status    = out_status_q;

endmodule

/* rtl/rcp_hit.sv */
// ----------------------------------------------------------------------------
// rcp_hit: cell coverage test
// Decides whether the cell under the scan counters is painted, in fixed point.
// ----------------------------------------------------------------------------
module rcp_hit #(
  parameter int SW = 32
) (
  input  logic                 outline_i,
  input  logic signed [SW-1:0] js_i,   // column, scaled
  input  logic signed [SW-1:0] jsn_i,  // column + 1, scaled
  input  logic signed [SW-1:0] is_i,   // row, scaled
  input  logic signed [SW-1:0] isn_i,  // row + 1, scaled
  input  logic signed [SW-1:0] xs0_i,  // floored left edge, scaled
  input  logic signed [SW-1:0] ys0_i,  // floored top edge, scaled
  input  logic signed [SW-1:0] xb_i,   // exact right edge
  input  logic signed [SW-1:0] yb_i,   // exact bottom edge
  output logic                 hit_o
);
  logic in_x, in_y, top, left, bottom, right, filled;

  always_comb begin
    in_x   = (js_i >= xs0_i) && (js_i < xb_i);
    in_y   = (is_i >= ys0_i) && (is_i < yb_i);
    top    = (is_i == ys0_i) && in_x;
    left   = (js_i == xs0_i) && in_y;
    // i >= yb - 1 is the same as i + 1 >= yb
    bottom = (isn_i >= yb_i) && (is_i < yb_i) && in_x;
    right  = (jsn_i >= xb_i) && (js_i < xb_i) && in_y;
    filled = (is_i >= ys0_i) && (is_i <= yb_i) && (js_i >= xs0_i) && (js_i <= xb_i);
    hit_o  = outline_i ? (top || left || bottom || right) : filled;
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the rectangle canvas painter
// Runs a table of directed commands, then random phases at several canvas
// settings. A cell-accurate mirror of the canvas predicts each result the table
// does not give, and each result is checked field by field. The sender works in
// bursts and the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import rcp_pkg::*;

  localparam int COORD_BITS     = DEF_COORD_BITS;
  localparam int FRAC_BITS      = DEF_FRAC_BITS;
  localparam int MAXW           = DEF_MAX_WIDTH;
  localparam int MAXH           = DEF_MAX_HEIGHT;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // A full 256 x 256 scan runs with no transfer at all.
  localparam int WATCHDOG_LIMIT = 270000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_PAUSE    = 4;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [1:0]                   command;
    logic [7:0]                   mode_char;
    logic signed [COORD_BITS-1:0] rect_x;
    logic signed [COORD_BITS-1:0] rect_y;
    logic signed [COORD_BITS-1:0] rect_width;
    logic signed [COORD_BITS-1:0] rect_height;
    logic [7:0]                   paint_char;
    logic [7:0]                   read_row;
    logic [7:0]                   read_col;
  } canvas_cmd_t;

  typedef struct {
    logic [7:0] cell_char;
    logic [1:0] status;
  } canvas_result_t;

  typedef struct {
    canvas_cmd_t cmd;
    bit          typed;
    logic [7:0]  cell_char;
    logic [1:0]  status;
  } dir_row_t;

  typedef struct {
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] bg;
    int         items;
  } canvas_phase_t;

  logic clk;
  logic rst_n;

  rcp_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  rcp_out_if                           out_ch ();
  rcp_cfg_if                           cfg_ch ();

  rectangle_canvas_painter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Mirror of the canvas and of the registers
  logic [7:0] canvas_mirror [MAXW*MAXH];
  logic [8:0] cols_reg = RST_CANVAS_WIDTH;
  logic [8:0] rows_reg = RST_CANVAS_HEIGHT;
  logic [7:0] bg_reg   = RST_BACKGROUND;

  canvas_result_t pending_results [$];
  dir_row_t       dir_tab [$];

  int err_cnt       = 0;
  int results_seen  = 0;
  int cmds_accepted = 0;
  int n_draw        = 0;
  int n_read        = 0;
  int n_clear       = 0;
  int n_settings    = 0;
  int burst_left    = 0;
  int hold_after    = 32'h7fff_ffff;
  int idle_cycles   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void report_err(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic longint size_in_use(logic [8:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return longint'(v);
  endfunction

  // Apply one command to the mirror and return the result it must produce.
  function automatic canvas_result_t paint_predict(canvas_cmd_t c);
    canvas_result_t r;
    longint cols, rows, i, j, is, js, x0, y0, xb, yb;
    bit in_x, in_y, hit;
    r.cell_char = 8'h00;
    r.status    = ST_OK;
    cols = size_in_use(cols_reg, MAXW);
    rows = size_in_use(rows_reg, MAXH);
    case (c.command)
      CMD_CLEAR: begin
        for (i = 0; i < rows; i++)
          for (j = 0; j < cols; j++) canvas_mirror[i*MAXW+j] = bg_reg;
      end
      CMD_READ: begin
        if (c.read_row >= rows || c.read_col >= cols) r.status = ST_OUTSIDE;
        else r.cell_char = canvas_mirror[c.read_row*MAXW+c.read_col];
      end
      CMD_DRAW: begin
        if (c.mode_char != MODE_OUTLINE && c.mode_char != MODE_FILLED) begin
          r.status = ST_BAD_MODE;
        end else if (c.rect_width <= 0 || c.rect_height <= 0) begin
          r.status = ST_BAD_SIZE;
        end else begin
          // floor the near edges, keep the far edges exact in fixed point
          x0 = longint'(c.rect_x) >>> FRAC_BITS;
          y0 = longint'(c.rect_y) >>> FRAC_BITS;
          xb = longint'(c.rect_x) + longint'(c.rect_width);
          yb = longint'(c.rect_y) + longint'(c.rect_height);
          for (i = 0; i < rows; i++) begin
            is = i * ONE;
            for (j = 0; j < cols; j++) begin
              js = j * ONE;
              if (c.mode_char == MODE_OUTLINE) begin
                in_x = j >= x0 && js < xb;
                in_y = i >= y0 && is < yb;
                hit = (i == y0 && in_x) || (j == x0 && in_y) ||
                      (is >= yb - ONE && is < yb && in_x) ||
                      (js >= xb - ONE && js < xb && in_y);
              end else begin
                hit = i >= y0 && is <= yb && j >= x0 && js <= xb;
              end
              if (hit) canvas_mirror[i*MAXW+j] = c.paint_char;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic canvas_cmd_t make_cmd(
    logic [1:0] cmd, logic [7:0] mode,
    logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
    logic signed [COORD_BITS-1:0] w, logic signed [COORD_BITS-1:0] h,
    logic [7:0] pc);
    canvas_cmd_t c;
    c.command     = cmd;
    c.mode_char   = mode;
    c.rect_x      = x;
    c.rect_y      = y;
    c.rect_width  = w;
    c.rect_height = h;
    c.paint_char  = pc;
    c.read_row    = 8'h00;
    c.read_col    = 8'h00;
    return c;
  endfunction

  function automatic canvas_cmd_t read_cell(logic [7:0] row, logic [7:0] col);
    canvas_cmd_t c;
    c = make_cmd(CMD_READ, 8'h00, '0, '0, '0, '0, 8'h00);
    c.read_row = row;
    c.read_col = col;
    return c;
  endfunction

  function automatic void add_row(canvas_cmd_t c, bit typed = 1'b0,
                                  logic [7:0] cell_exp = 8'h00, logic [1:0] st = ST_OK);
    dir_row_t r;
    r.cmd       = c;
    r.typed     = typed;
    r.cell_char = cell_exp;
    r.status    = st;
    dir_tab.push_back(r);
  endfunction

  function automatic canvas_cmd_t random_cmd();
    canvas_cmd_t c;
    int kind, cols, rows, span_x, span_y;
    cols   = int'(size_in_use(cols_reg, MAXW));
    rows   = int'(size_in_use(rows_reg, MAXH));
    span_x = cols * ONE;
    span_y = rows * ONE;
    // start from noise in every field, then shape the fields that matter
    c.command     = 2'($urandom);
    c.mode_char   = 8'($urandom);
    c.rect_x      = COORD_BITS'($urandom);
    c.rect_y      = COORD_BITS'($urandom);
    c.rect_width  = COORD_BITS'($urandom);
    c.rect_height = COORD_BITS'($urandom);
    c.paint_char  = 8'($urandom);
    c.read_row    = 8'($urandom);
    c.read_col    = 8'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      c.command     = CMD_DRAW;
      c.mode_char   = $urandom_range(0, 1) ? MODE_OUTLINE : MODE_FILLED;
      c.rect_x      = COORD_BITS'(int'($urandom_range(0, span_x + 4 * ONE)) - 2 * ONE);
      c.rect_y      = COORD_BITS'(int'($urandom_range(0, span_y + 4 * ONE)) - 2 * ONE);
      c.rect_width  = COORD_BITS'($urandom_range(1, $urandom_range(0, 1) ?
                                                    3 * ONE : span_x + 2 * ONE));
      c.rect_height = COORD_BITS'($urandom_range(1, $urandom_range(0, 1) ?
                                                    3 * ONE : span_y + 2 * ONE));
    end else if (kind < 50) begin
      c.command = CMD_DRAW;
      if ($urandom_range(0, 1)) c.mode_char = $urandom_range(0, 1) ? MODE_OUTLINE : MODE_FILLED;
    end else if (kind < 85) begin
      c.command = CMD_READ;
      if ($urandom_range(0, 9) < 7) begin
        c.read_row = 8'($urandom_range(0, rows - 1));
        c.read_col = 8'($urandom_range(0, cols - 1));
      end
    end else if (kind < 90) begin
      c.command = CMD_CLEAR;
    end else if (kind < 95) begin
      c.command = CMD_UNUSED;
    end else begin
      c.command   = CMD_DRAW;
      c.mode_char = $urandom_range(0, 1) ? MODE_OUTLINE : MODE_FILLED;
      if ($urandom_range(0, 1)) c.rect_width = COORD_BITS'(-int'($urandom_range(0, 4 * ONE)));
      else c.rect_height = COORD_BITS'(-int'($urandom_range(0, 4 * ONE)));
    end
    return c;
  endfunction

  task automatic send_cmd(input canvas_cmd_t c, input bit typed = 1'b0,
                          input logic [7:0] cell_exp = 8'h00, input logic [1:0] st = ST_OK);
    int gap;
    canvas_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c.command;
    in_ch.mode_char   <= c.mode_char;
    in_ch.rect_x      <= c.rect_x;
    in_ch.rect_y      <= c.rect_y;
    in_ch.rect_width  <= c.rect_width;
    in_ch.rect_height <= c.rect_height;
    in_ch.paint_char  <= c.paint_char;
    in_ch.read_row    <= c.read_row;
    in_ch.read_col    <= c.read_col;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = paint_predict(c);
    if (typed) begin
      r.cell_char = cell_exp;
      r.status    = st;
    end
    pending_results.push_back(r);
    cmds_accepted++;
    case (c.command)
      CMD_DRAW:  n_draw++;
      CMD_READ:  n_read++;
      CMD_CLEAR: n_clear++;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_CANVAS_WIDTH:  cols_reg = val;
      CFG_CANVAS_HEIGHT: rows_reg = val;
      CFG_BACKGROUND:    bg_reg   = val[7:0];
      default: ;
    endcase
  endtask

  // Drop the command channel, drain, then write all three registers.
  task automatic set_canvas(input logic [8:0] w, input logic [8:0] h, input logic [7:0] bg);
    in_ch.valid <= 1'b0;
    wait_idle();
    write_reg(CFG_CANVAS_WIDTH, w);
    write_reg(CFG_CANVAS_HEIGHT, h);
    write_reg(CFG_BACKGROUND, {1'($urandom), bg});
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Sender: directed table, then random phases
  initial begin
    canvas_phase_t phases [5];
    canvas_cmd_t   c;
    int            resize_at, n;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= '0;
    in_ch.mode_char   <= '0;
    in_ch.rect_x      <= '0;
    in_ch.rect_y      <= '0;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    in_ch.paint_char  <= '0;
    in_ch.read_row    <= '0;
    in_ch.read_col    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;

    // Reset sizes and background
    add_row(make_cmd(CMD_CLEAR, 8'h00, '0, '0, '0, '0, 8'h00), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd0, 8'd0), 1'b1, RST_BACKGROUND, ST_OK);
    add_row(read_cell(8'd255, 8'd255), 1'b1, RST_BACKGROUND, ST_OK);
    add_row(make_cmd(CMD_DRAW, 8'h00, '0, '0, 20'h00100, 20'h00100, 8'h41),
            1'b1, 8'h00, ST_BAD_MODE);
    // bad mode wins over a bad size
    add_row(make_cmd(CMD_DRAW, 8'hFF, '0, '0, 20'hFFFFF, 20'h00100, 8'h41),
            1'b1, 8'h00, ST_BAD_MODE);
    add_row(make_cmd(CMD_DRAW, MODE_OUTLINE, '0, '0, 20'h00000, 20'h00100, 8'h41),
            1'b1, 8'h00, ST_BAD_SIZE);
    add_row(make_cmd(CMD_DRAW, MODE_FILLED, '0, '0, 20'h00100, 20'h80000, 8'h41),
            1'b1, 8'h00, ST_BAD_SIZE);
    add_row(make_cmd(CMD_UNUSED, MODE_FILLED, '0, '0, 20'h00100, 20'h00100, 8'h41),
            1'b1, 8'h00, ST_OK);
    add_row(make_cmd(CMD_DRAW, MODE_OUTLINE, 20'h00180, 20'h00040, 20'h7FFFF, 20'h7FFFF,
                     8'h23), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd0, 8'd1));
    add_row(read_cell(8'd200, 8'd1));
    add_row(read_cell(8'd255, 8'd255));
    resize_at = dir_tab.size();
    // 8 x 6 canvas
    add_row(make_cmd(CMD_CLEAR, 8'h00, '0, '0, '0, '0, 8'h00), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd5, 8'd7), 1'b1, 8'h2E, ST_OK);
    add_row(read_cell(8'd6, 8'd0), 1'b1, 8'h00, ST_OUTSIDE);
    add_row(read_cell(8'd0, 8'd8), 1'b1, 8'h00, ST_OUTSIDE);
    add_row(read_cell(8'd255, 8'd255), 1'b1, 8'h00, ST_OUTSIDE);
    add_row(make_cmd(CMD_DRAW, MODE_FILLED, 20'h00100, 20'h00180, 20'h00280, 20'h00100,
                     8'h2A), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd2, 8'd3));
    // negative left edge floors below zero
    add_row(make_cmd(CMD_DRAW, MODE_OUTLINE, 20'hFFF80, 20'h00200, 20'h00500, 20'h00300,
                     8'h6F), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd2, 8'd0));
    add_row(read_cell(8'd4, 8'd4));
    add_row(read_cell(8'd3, 8'd4));
    add_row(make_cmd(CMD_DRAW, MODE_FILLED, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h7FFFF,
                     8'hFF), 1'b1, 8'h00, ST_OK);
    add_row(read_cell(8'd5, 8'd7));

    phases[0] = '{9'd5,   9'd4,   8'h2E, 35};
    phases[1] = '{9'd0,   9'd511, 8'hFF, 15};
    phases[2] = '{9'd300, 9'd0,   8'h00, 15};
    phases[3] = '{9'd17,  9'd13,  8'($urandom), 30};
    phases[4] = '{9'd256, 9'd256, 8'h20, 5};
    hold_after = dir_tab.size() + 8;

    wait (rst_n === 1'b1);
    @(posedge clk);
    n_settings = 1;

    for (int k = 0; k < dir_tab.size(); k++) begin
      if (k == resize_at) set_canvas(9'd8, 9'd6, 8'h2E);
      send_cmd(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].cell_char, dir_tab[k].status);
    end

    foreach (phases[p]) begin
      set_canvas(phases[p].width, phases[p].height, phases[p].bg);
      // every cell in use is written before any read
      send_cmd(make_cmd(CMD_CLEAR, 8'($urandom), '0, '0, '0, '0, 8'h00));
      n = 1;
      while (n < phases[p].items) begin
        c = random_cmd();
        send_cmd(c);
        if (c.command != CMD_UNUSED) n++;
      end
    end

    in_ch.valid <= 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_err($sformatf("%0d results never arrived", pending_results.size()));
    $display("Sent %0d commands (%0d draws, %0d reads, %0d clears) over %0d canvas settings.",
             cmds_accepted, n_draw, n_read, n_clear, n_settings);
    $display("Checked %0d results, %0d mismatches.", results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: stall pattern of its own, with one long hold-off to back up the input
  initial begin
    int  mode_left;
    int  stall_mode;
    bit  held;
    mode_left = 0;
    stall_mode = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && cmds_accepted >= hold_after) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left  = $urandom_range(16, 96);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    canvas_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_err($sformatf("result with nothing pending: cell_char=%02h status=%0d",
                             out_ch.cell_char, out_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cell_char !== want.cell_char)
          report_err($sformatf("cell_char: expected %02h, got %02h",
                               want.cell_char, out_ch.cell_char));
        if (out_ch.status !== want.status)
          report_err($sformatf("status: expected %0d, got %0d", want.status, out_ch.status));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/rcp_pkg.sv
rtl/rcp_if.sv
rtl/rcp_hit.sv
rtl/rectangle_canvas_painter.sv
tb/tb.sv
